// ===== src/ssp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the stock span stream
// Word formats on both channels, stack entry format and memory port bundle.
// ---------------------------------------------------------------------------
package ssp_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(STACK_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

	typedef struct packed {
		logic signed [31:0] price;
		logic               last_day;
	} item_t;

	typedef struct packed {
		logic [31:0] span;
		logic        history_lost;
	} result_t;

	typedef struct packed {
		logic signed [31:0] price;
		logic        [31:0] span;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [PTR_W-1:0] rd_addr;
		logic             wr_en;
		logic [PTR_W-1:0] wr_addr;
		entry_t           wr_data;
	} ram_req_t;

	typedef struct packed {
		logic    valid;
		result_t result;
	} push_t;

endpackage

// ===== src/ssp_stack_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssp_stack_ram: stack storage
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ssp_stack_ram (
	input  wire logic              clk,
	input  wire ssp_pkg::ram_req_t req,
	output      ssp_pkg::entry_t   rd_data
);

	ssp_pkg::entry_t mem [ssp_pkg::STACK_DEPTH];
	ssp_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== src/ssp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssp_ctrl: span walk sequencer
// Pops lower-priced entries one per cycle, then pushes the new pair on a
// circular stack whose oldest entry is overwritten when full.
// ---------------------------------------------------------------------------
module ssp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ssp_pkg::item_t    item,
	input  wire logic              item_valid,
	output      logic              item_stall,
	input  wire logic              res_free,
	output      ssp_pkg::push_t    push,
	output      ssp_pkg::ram_req_t ram_req,
	input  wire ssp_pkg::entry_t   rd_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]                  state_q;
	logic [ssp_pkg::CNT_W-1:0]   count_q;
	logic [ssp_pkg::PTR_W-1:0]   top_q;
	logic                        lost_q;
	logic signed [31:0]          price_q;
	logic                        last_q;
	logic [31:0]                 span_q;

	logic                        accept;
	logic                        pop;
	logic                        push_go;
	logic                        full;
	logic                        lost_nxt;
	logic [ssp_pkg::CNT_W-1:0]   count_dec;
	logic [ssp_pkg::PTR_W-1:0]   top_dec;
	logic [ssp_pkg::PTR_W-1:0]   top_inc;
	logic [32:0]                 span_wide;
	logic [31:0]                 span_sum;

	always_comb begin
		accept    = item_valid && (state_q == ST_IDLE);
		pop       = (state_q == ST_WALK) && (price_q > rd_data.price);
		push_go   = (state_q == ST_PUSH) && res_free;
		full      = (count_q == ssp_pkg::CNT_FULL);
		lost_nxt  = lost_q | full;
		count_dec = count_q - ssp_pkg::CNT_W'(1);
		top_dec   = (top_q == '0) ? ssp_pkg::PTR_MAX : top_q - ssp_pkg::PTR_W'(1);
		top_inc   = (top_q == ssp_pkg::PTR_MAX) ? '0 : top_q + ssp_pkg::PTR_W'(1);
		// saturate the running span at the field maximum
		span_wide = {1'b0, span_q} + {1'b0, rd_data.span};
		span_sum  = span_wide[32] ? '1 : span_wide[31:0];
	end

	always_comb begin
		ram_req.rd_en         = (accept && (count_q != '0)) || (pop && (count_dec != '0));
		ram_req.rd_addr       = (state_q == ST_WALK) ? top_dec : top_q;
		ram_req.wr_en         = push_go;
		ram_req.wr_addr       = top_inc;
		ram_req.wr_data.price = price_q;
		ram_req.wr_data.span  = span_q;
	end

	assign push.valid               = push_go;
	assign push.result.span         = span_q;
	assign push.result.history_lost = lost_nxt;
	assign item_stall               = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			top_q   <= '0;
			lost_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= (count_q != '0) ? ST_WALK : ST_PUSH;
					end
				end
				ST_WALK: begin
					if (pop) begin
						count_q <= count_dec;
						top_q   <= top_dec;
						if (count_dec == '0) begin
							state_q <= ST_PUSH;
						end
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (res_free) begin
						top_q   <= top_inc;
						// a full stack overwrites its oldest entry, so the count holds
						if (last_q) begin
							count_q <= '0;
						end else if (!full) begin
							count_q <= count_q + ssp_pkg::CNT_W'(1);
						end
						lost_q  <= last_q ? 1'b0 : lost_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= item.price;
			last_q  <= item.last_day;
			span_q  <= 32'd1;
		end else if (pop) begin
			span_q  <= span_sum;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ssp_pkg::CNT_FULL)
		else $error("stack count beyond depth");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (count_q != '0))
		else $error("walk on empty stack");

	a_series_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(push_go && last_q) |=> (count_q == '0) && !lost_q)
		else $error("stack not cleared after last day");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.rd_en && ram_req.wr_en))
		else $error("read and write in the same cycle");
`endif

endmodule
`default_nettype wire

// ===== src/stock_span_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stock_span_stream: streaming stock span over a bounded monotonic stack
// Gives, for each price, one plus the spans of popped lower-priced entries.
// ---------------------------------------------------------------------------
//  channel | handshake                 | word
//  --------+---------------------------+-------------------------------
//  item    | item_valid / item_stall   | price (signed 32), last_day
//  result  | result_valid/result_stall | span (32, saturating), history_lost
//
//  Each item walks the stack, popping lower-priced entries until the stack is
//  empty (an empty stack skips the walk) or an equal or higher entry is met:
//  the stack memory gives one read per cycle, so the walk pops one entry a cycle.
//  Reset empties the stack and clears the loss flag; memory contents are not
//  cleared, only the count is. The result register frees the input side, so
//  the next word is taken while a result waits; the push waits on result_stall.
// ---------------------------------------------------------------------------
module stock_span_stream (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output      logic             item_stall,
	input  wire ssp_pkg::item_t   item,
	output      logic             result_valid,
	input  wire logic             result_stall,
	output      ssp_pkg::result_t result
);

	ssp_pkg::ram_req_t ram_req;
	ssp_pkg::entry_t   rd_data;
	ssp_pkg::push_t    push;
	ssp_pkg::result_t  result_q;
	logic              result_valid_q;
	logic              res_free;

	assign res_free = !result_valid_q || !result_stall;

	ssp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.res_free   (res_free),
		.push       (push),
		.ram_req    (ram_req),
		.rd_data    (rd_data)
	);

	ssp_stack_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push.valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// hold the word until taken
	always_ff @(posedge clk) begin
		if (push.valid) begin
			result_q <= push.result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire
